// ----- src/hbd_pkg.sv -----
package hbd_pkg;

    localparam int unsigned ByteBits   = 8;
    localparam int unsigned PosBits    = 4;
    localparam int unsigned RunBits    = 3;

    localparam logic [RunBits-1:0] RunFirst = 3'd1;
    localparam logic [RunBits-1:0] RunStuff = 3'd5;
    localparam logic [RunBits-1:0] RunFlag  = 3'd6;
    localparam logic [RunBits-1:0] RunAbort = 3'd7;

    localparam logic [PosBits-1:0] PosFull  = 4'd8;
    localparam logic [PosBits-1:0] PosFirst = 4'd1;

    localparam logic [ByteBits-1:0] ReplyByteIndex = 8'd3;
    localparam logic [ByteBits-1:0] NoReplyCodeA   = 8'd3;
    localparam logic [ByteBits-1:0] NoReplyCodeB   = 8'd5;

    typedef struct packed {
        logic [ByteBits-1:0] data_byte;
        logic                in_frame;
        logic                reply_decided;
        logic                reply_request;
    } hbd_result_t;

    typedef struct packed {
        logic        emit;
        hbd_result_t result;
    } hbd_emit_t;

    function automatic logic [ByteBits-1:0] mirror8(input logic [ByteBits-1:0] x);
        logic [ByteBits-1:0] r;
        for (int i = 0; i < ByteBits; i++)
        begin
            r[i] = x[ByteBits-1-i];
        end
        return r;
    endfunction

endpackage

// ----- src/hbd_in_if.sv -----
interface hbd_in_if;
    logic valid;
    logic ready;
    logic line_bit;

    modport source (output valid, output line_bit, input ready);
    modport sink (input valid, input line_bit, output ready);
endinterface

// ----- src/hbd_out_if.sv -----
interface hbd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       in_frame;
    logic       reply_decided;
    logic       reply_request;

    modport source (output valid, output data_byte, output in_frame,
                    output reply_decided, output reply_request, input ready);
    modport sink (input valid, input data_byte, input in_frame,
                  input reply_decided, input reply_request, output ready);
endinterface

// ----- src/hdlc_bit_destuff_receiver.sv -----
// HDLC bit-destuffing receiver.
// Channel line: one sampled line bit per request (valid/ready/line_bit).
// Channel rx: one decoded byte per request, with in_frame, reply_decided
//   and reply_request; a byte comes out after every eighth kept bit, so
//   most line bits produce no rx request.
// cfg_we/cfg_wdata write invert_input; write it only while idle.
// Throughput: one line bit per cycle unless stalled; the per-bit decode is a single pass
//   of logic in front of the result register.
// Latency: a byte is valid on rx the cycle after the line bit that
//   completes it is taken.
// Reset: frame state clears, the byte count is armed and invert_input
//   reads 1; the result register is empty.
// Stall: while rx holds a byte that is not taken, line.ready drops and
//   the decoder state holds; line.ready is high whenever the result
//   register is empty or is being drained in the same cycle.
module hdlc_bit_destuff_receiver
    import hbd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    hbd_in_if.sink    line,
    hbd_out_if.source rx,
    input  logic      cfg_we,
    input  logic      cfg_wdata
);

    logic      invert_input_reg;
    logic      can_take;
    logic      accept;
    hbd_emit_t emit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            invert_input_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            invert_input_reg <= cfg_wdata;
        end
    end

    assign line.ready = can_take;
    assign accept     = line.valid && can_take;

    hbd_decoder u_decoder (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .line_bit (line.line_bit),
        .invert   (invert_input_reg),
        .emit     (emit)
    );

    hbd_out_reg u_out_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (accept && emit.emit),
        .result   (emit.result),
        .can_take (can_take),
        .rx       (rx)
    );

endmodule

// ----- src/hbd_decoder.sv -----
module hbd_decoder
    import hbd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      accept,
    input  logic      line_bit,
    input  logic      invert,
    output hbd_emit_t emit
);

    logic [ByteBits-1:0] shift_byte_reg, shift_byte_next;
    logic [RunBits-1:0]  ones_run_reg, ones_run_next;
    logic                stuff_pending_reg, stuff_pending_next;
    logic                frame_flag_reg, frame_flag_next;
    logic                abort_seen_reg, abort_seen_next;
    logic [PosBits-1:0]  bit_position_reg, bit_position_next;
    logic [ByteBits-1:0] frame_byte_count_reg, frame_byte_count_next;
    logic                count_armed_reg, count_armed_next;
    logic                reply_latched_reg, reply_latched_next;

    always_comb
    begin
        logic                b;
        logic [PosBits-1:0]  pos;
        logic [ByteBits-1:0] data;

        b    = line_bit ^ invert;
        data = '0;

        shift_byte_next       = {shift_byte_reg[ByteBits-2:0], b};
        ones_run_next         = ones_run_reg;
        stuff_pending_next    = stuff_pending_reg;
        frame_flag_next       = frame_flag_reg;
        abort_seen_next       = abort_seen_reg;
        pos                   = bit_position_reg;
        frame_byte_count_next = frame_byte_count_reg;
        count_armed_next      = count_armed_reg;
        reply_latched_next    = reply_latched_reg;
        emit                  = '0;

        if (b)
        begin
            ones_run_next = ones_run_reg + RunFirst;
            if (ones_run_next == RunFirst && !frame_flag_reg)
            begin
                pos = PosFirst;
            end
            else if (ones_run_next == RunStuff)
            begin
                stuff_pending_next = 1'b1;
            end
            else if (ones_run_next == RunFlag)
            begin
                stuff_pending_next = 1'b0;
                frame_flag_next    = ~frame_flag_reg;
            end
            else if (ones_run_next == RunAbort)
            begin
                stuff_pending_next = 1'b0;
                frame_flag_next    = 1'b0;
                abort_seen_next    = 1'b1;
                ones_run_next      = '0;
            end
        end
        else
        begin
            // drop the stuffed zero
            if (stuff_pending_reg)
            begin
                shift_byte_next    = {1'b0, shift_byte_reg[ByteBits-2:0]};
                pos                = bit_position_reg - PosFirst;
                stuff_pending_next = 1'b0;
            end
            else if (abort_seen_reg)
            begin
                frame_flag_next = 1'b0;
                abort_seen_next = 1'b0;
            end
            else if (frame_flag_reg && count_armed_reg)
            begin
                frame_byte_count_next = '0;
                count_armed_next      = 1'b0;
                reply_latched_next    = 1'b0;
            end
            if (!frame_flag_next)
            begin
                count_armed_next = 1'b1;
            end
            ones_run_next = '0;
        end

        bit_position_next = pos + PosFirst;

        if (bit_position_next == PosFull)
        begin
            data = mirror8(shift_byte_next);
            emit.emit = 1'b1;
            emit.result.data_byte = data;
            emit.result.in_frame  = frame_flag_next;
            if (!reply_latched_next && frame_flag_next)
            begin
                frame_byte_count_next = frame_byte_count_next + 8'd1;
                if (frame_byte_count_next == ReplyByteIndex)
                begin
                    reply_latched_next          = 1'b1;
                    emit.result.reply_decided   = 1'b1;
                    emit.result.reply_request   = (data != NoReplyCodeA) &&
                                                  (data != NoReplyCodeB);
                end
            end
            bit_position_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_byte_reg       <= '0;
            ones_run_reg         <= '0;
            stuff_pending_reg    <= 1'b0;
            frame_flag_reg       <= 1'b0;
            abort_seen_reg       <= 1'b0;
            bit_position_reg     <= '0;
            frame_byte_count_reg <= '0;
            count_armed_reg      <= 1'b1;
            reply_latched_reg    <= 1'b0;
        end
        else if (accept)
        begin
            shift_byte_reg       <= shift_byte_next;
            ones_run_reg         <= ones_run_next;
            stuff_pending_reg    <= stuff_pending_next;
            frame_flag_reg       <= frame_flag_next;
            abort_seen_reg       <= abort_seen_next;
            bit_position_reg     <= bit_position_next;
            frame_byte_count_reg <= frame_byte_count_next;
            count_armed_reg      <= count_armed_next;
            reply_latched_reg    <= reply_latched_next;
        end
    end

    a_pos_below_full: assert property (@(posedge clk) disable iff (!rst_n)
        bit_position_reg < PosFull)
        else $error("bit position reached a full byte");

    a_run_never_seven: assert property (@(posedge clk) disable iff (!rst_n)
        ones_run_reg != RunAbort)
        else $error("ones run held an abort count");

    a_request_needs_decision: assert property (@(posedge clk) disable iff (!rst_n)
        emit.result.reply_request |-> emit.result.reply_decided)
        else $error("reply request without decision");

    a_decision_latches: assert property (@(posedge clk) disable iff (!rst_n)
        accept && emit.emit && emit.result.reply_decided |=> reply_latched_reg)
        else $error("reply decision not latched");

endmodule

// ----- src/hbd_out_reg.sv -----
module hbd_out_reg
    import hbd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  hbd_result_t      result,
    output logic             can_take,
    hbd_out_if.source        rx
);

    logic        valid_reg, valid_next;
    hbd_result_t result_reg;

    assign can_take = !valid_reg || rx.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (rx.ready)
        begin
            valid_next = 1'b0;
        end
        if (load)
        begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result;
        end
    end

    assign rx.valid         = valid_reg;
    assign rx.data_byte     = result_reg.data_byte;
    assign rx.in_frame      = result_reg.in_frame;
    assign rx.reply_decided = result_reg.reply_decided;
    assign rx.reply_request = result_reg.reply_request;

endmodule
